### design/lcv_pkg.sv
// ----------------------------------------------------------------------------
// lcv_pkg
// Shared types, register map and constants of the light color vote block.
// ----------------------------------------------------------------------------
`default_nettype none

package lcv_pkg;

   localparam int COORD_BITS    = 12;
   localparam int PIX_BITS      = 24;
   localparam int CH_BITS       = 8;
   localparam int COUNT_BITS    = 24;
   localparam int SUM_BITS      = 32;
   localparam int PCT_BITS      = 8;
   localparam int FMT_BITS      = 2;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 3;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int SAT_BITS      = 2 * CH_BITS;
   localparam int PROD_BITS     = SUM_BITS + PCT_BITS + 1;

   localparam logic [CH_BITS-1:0]    CH_MAX     = 8'd255;
   localparam logic [PCT_BITS-1:0]   PCT_BASE   = 8'd100;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 24'hFFFFFF;
   localparam logic [SUM_BITS-1:0]   SUM_MAX    = 32'hFFFFFFFF;

   localparam logic [FMT_BITS-1:0] FMT_RGB888 = 2'd0;
   localparam logic [FMT_BITS-1:0] FMT_BGR565 = 2'd1;

   localparam logic [REG_IDX_BITS-1:0] REG_MIN_SAT    = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_MIN_VALUE  = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_RED_ADV    = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_PIX_FORMAT = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_WIN_LEFT   = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_WIN_TOP    = 3'd5;
   localparam logic [REG_IDX_BITS-1:0] REG_WIN_RIGHT  = 3'd6;
   localparam logic [REG_IDX_BITS-1:0] REG_WIN_BOTTOM = 3'd7;

   localparam logic [CH_BITS-1:0]      RST_MIN_SAT   = 8'd70;
   localparam logic [CH_BITS-1:0]      RST_MIN_VALUE = 8'd90;
   localparam logic [PCT_BITS-1:0]     RST_RED_ADV   = 8'd25;
   localparam logic [COORD_BITS:0]     RST_WIN_END   = (COORD_BITS + 1)'(1 << COORD_BITS);

   typedef struct packed {
      logic [PIX_BITS-1:0]   raw_pixel;
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
      logic                  frame_end;
   } req_type;

   typedef struct packed {
      logic                  light_red;
      logic [COUNT_BITS-1:0] active_total;
      logic [SUM_BITS-1:0]   red_total;
      logic [SUM_BITS-1:0]   green_total;
   } rsp_type;

   typedef struct packed {
      logic [CH_BITS-1:0]    min_saturation;
      logic [CH_BITS-1:0]    min_value;
      logic [PCT_BITS-1:0]   red_advantage_pct;
      logic [FMT_BITS-1:0]   pixel_format;
      logic [COORD_BITS-1:0] win_left;
      logic [COORD_BITS-1:0] win_top;
      logic [COORD_BITS:0]   win_right;
      logic [COORD_BITS:0]   win_bottom;
   } cfg_type;

   typedef struct packed {
      logic               active;
      logic               supported;
      logic               last;
      logic [CH_BITS-1:0] red;
      logic [CH_BITS-1:0] green;
   } entry_type;

endpackage

`default_nettype wire

### design/lcv_front.sv
// ----------------------------------------------------------------------------
// lcv_front
// Pixel intake: window test, unpacking and the active-pixel classification.
// ----------------------------------------------------------------------------
`default_nettype none

module lcv_front import lcv_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      req_valid,
   output logic           req_ready,
   input  wire req_type   req_data,
   input  wire logic      q_full,
   output logic           q_push,
   output entry_type      q_data
);

   logic [CH_BITS-1:0] red, green, blue, hi, lo;
   logic               in_window, supported, advance;

   logic               a_valid_ff;
   logic [CH_BITS-1:0] a_red_ff, a_green_ff, a_hi_ff, a_lo_ff;
   logic               a_use_ff, a_sup_ff, a_last_ff;

   logic                b_valid_ff;
   logic [CH_BITS-1:0]  b_red_ff, b_green_ff, b_hi_ff;
   logic                b_use_ff, b_sup_ff, b_last_ff;
   logic [SAT_BITS-1:0] b_spread_ff, b_floor_ff;
   logic [SAT_BITS-1:0] spread_in, floor_in;
   logic                sat_ok;

   always_comb begin
      if (cfg.pixel_format == FMT_BGR565) begin
         red   = {req_data.raw_pixel[15:11], req_data.raw_pixel[15:13]};
         green = {req_data.raw_pixel[10:5],  req_data.raw_pixel[10:9]};
         blue  = {req_data.raw_pixel[4:0],   req_data.raw_pixel[4:2]};
      end else begin
         red   = req_data.raw_pixel[23:16];
         green = req_data.raw_pixel[15:8];
         blue  = req_data.raw_pixel[7:0];
      end
      hi = red;
      lo = red;
      if (green > hi) hi = green;
      if (blue > hi)  hi = blue;
      if (green < lo) lo = green;
      if (blue < lo)  lo = blue;
      supported = (cfg.pixel_format == FMT_RGB888) || (cfg.pixel_format == FMT_BGR565);
      in_window = (req_data.col >= cfg.win_left) && ({1'b0, req_data.col} < cfg.win_right) &&
                  (req_data.row >= cfg.win_top)  && ({1'b0, req_data.row} < cfg.win_bottom);
   end

   assign advance   = !(b_valid_ff && q_full);
   assign req_ready = advance;

   // saturation test without a divider: delta*255/hi >= m  <=>  delta*255 >= m*hi
   assign spread_in = SAT_BITS'(a_hi_ff - a_lo_ff) * SAT_BITS'(CH_MAX);
   assign floor_in  = SAT_BITS'(cfg.min_saturation) * SAT_BITS'(a_hi_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_red_ff    <= red;
         a_green_ff  <= green;
         a_hi_ff     <= hi;
         a_lo_ff     <= lo;
         a_use_ff    <= supported && in_window;
         a_sup_ff    <= supported;
         a_last_ff   <= req_data.frame_end;
         b_red_ff    <= a_red_ff;
         b_green_ff  <= a_green_ff;
         b_hi_ff     <= a_hi_ff;
         b_use_ff    <= a_use_ff;
         b_sup_ff    <= a_sup_ff;
         b_last_ff   <= a_last_ff;
         b_spread_ff <= spread_in;
         b_floor_ff  <= floor_in;
      end
   end

   assign sat_ok = (b_hi_ff == '0) ? (cfg.min_saturation == '0) : (b_spread_ff >= b_floor_ff);

   assign q_push           = b_valid_ff && !q_full;
   assign q_data.active    = b_use_ff && sat_ok && (b_hi_ff >= cfg.min_value);
   assign q_data.supported = b_sup_ff;
   assign q_data.last      = b_last_ff;
   assign q_data.red       = b_red_ff;
   assign q_data.green     = b_green_ff;

endmodule

`default_nettype wire

### design/lcv_queue.sv
// ----------------------------------------------------------------------------
// lcv_queue
// Short FIFO of classified pixels between the intake and the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module lcv_queue import lcv_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_data,
   input  wire logic      pop,
   output logic           full,
   output logic           valid,
   output entry_type      head_data
);

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_BITS:0]     count_ff, count_in;

   assign full      = (count_ff == (QPTR_BITS + 1)'(QUEUE_DEPTH));
   assign valid     = (count_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

### design/lcv_back.sv
// ----------------------------------------------------------------------------
// lcv_back
// Accumulator and vote: saturating count and sums, verdict on frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module lcv_back import lcv_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      q_valid,
   input  wire entry_type q_data,
   output logic           q_pop,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output rsp_type        rsp_data
);

   typedef enum logic [2:0] {
      ST_RUN = 3'b001,
      ST_MUL = 3'b010,
      ST_CMP = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] count_ff, count_in, res_count_ff;
   logic [SUM_BITS-1:0]   red_sum_ff, red_sum_in, res_red_ff;
   logic [SUM_BITS-1:0]   green_sum_ff, green_sum_in, res_green_ff;
   logic [SUM_BITS:0]     red_add, green_add;
   logic [PROD_BITS-1:0]  scaled_ff, need_ff;
   logic                  rsp_valid_ff, light_red_ff, vote;

   assign q_pop = q_valid && (state_ff == ST_RUN) && (!q_data.last || !rsp_valid_ff);

   assign red_add   = {1'b0, red_sum_ff}   + (SUM_BITS + 1)'(q_data.red);
   assign green_add = {1'b0, green_sum_ff} + (SUM_BITS + 1)'(q_data.green);

   always_comb begin
      count_in     = count_ff;
      red_sum_in   = red_sum_ff;
      green_sum_in = green_sum_ff;
      if (q_data.active) begin
         if (count_ff != COUNT_MAX) count_in = count_ff + 1'b1;
         red_sum_in   = red_add[SUM_BITS]   ? SUM_MAX : red_add[SUM_BITS-1:0];
         green_sum_in = green_add[SUM_BITS] ? SUM_MAX : green_add[SUM_BITS-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN: if (q_pop && q_data.last) state_in = ST_MUL;
         ST_MUL: state_in = ST_CMP;
         ST_CMP: state_in = ST_RUN;
         default: state_in = ST_RUN;
      endcase
   end

   assign vote = (res_count_ff != '0) && (res_red_ff > res_green_ff) && (scaled_ff >= need_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         count_ff     <= '0;
         red_sum_ff   <= '0;
         green_sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (q_pop) begin
            if (q_data.last) begin
               count_ff     <= '0;
               red_sum_ff   <= '0;
               green_sum_ff <= '0;
            end else begin
               count_ff     <= count_in;
               red_sum_ff   <= red_sum_in;
               green_sum_ff <= green_sum_in;
            end
         end
         if (state_ff == ST_CMP)          rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_data.last) begin
         res_count_ff <= q_data.supported ? count_in     : '0;
         res_red_ff   <= q_data.supported ? red_sum_in   : '0;
         res_green_ff <= q_data.supported ? green_sum_in : '0;
      end
      if (state_ff == ST_MUL) begin
         scaled_ff <= PROD_BITS'(res_red_ff) * PROD_BITS'(PCT_BASE);
         need_ff   <= PROD_BITS'(res_green_ff) *
                      PROD_BITS'({1'b0, PCT_BASE} + {1'b0, cfg.red_advantage_pct});
      end
      if (state_ff == ST_CMP) light_red_ff <= vote;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.light_red    = light_red_ff;
   assign rsp_data.active_total = res_count_ff;
   assign rsp_data.red_total    = res_red_ff;
   assign rsp_data.green_total  = res_green_ff;

endmodule

`default_nettype wire

### design/light_color_vote.sv
// ----------------------------------------------------------------------------
// light_color_vote
// Red or green verdict from the active pixels inside a window of the frame.
// ----------------------------------------------------------------------------
// Pixels transfer one per clock unless a full queue stalls the intake. Each
// passes a two-stage intake (window test, unpacking, saturation products),
// waits in a four-entry queue and is summed by the accumulator one per clock
// while no frame_end is being handled or waiting. A frame_end pixel holds the
// accumulator while it registers the final sums, the vote products and the
// compare; the next frame still flows in meanwhile, and a further frame_end
// waits in the queue until the previous result has been taken.
`default_nettype none

module light_color_vote import lcv_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_type                  req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_type                       rsp_data,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                          csr_pready
);

   cfg_type                 cfg_ff;
   logic                    csr_write;
   logic [REG_IDX_BITS-1:0] reg_idx;
   logic                    q_full, q_push, q_pop, q_valid;
   entry_type               q_in, q_head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_saturation    <= RST_MIN_SAT;
         cfg_ff.min_value         <= RST_MIN_VALUE;
         cfg_ff.red_advantage_pct <= RST_RED_ADV;
         cfg_ff.pixel_format      <= FMT_RGB888;
         cfg_ff.win_left          <= '0;
         cfg_ff.win_top           <= '0;
         cfg_ff.win_right         <= RST_WIN_END;
         cfg_ff.win_bottom        <= RST_WIN_END;
      end else if (csr_write) begin
         unique case (reg_idx)
            REG_MIN_SAT:    cfg_ff.min_saturation    <= csr_pwdata[CH_BITS-1:0];
            REG_MIN_VALUE:  cfg_ff.min_value         <= csr_pwdata[CH_BITS-1:0];
            REG_RED_ADV:    cfg_ff.red_advantage_pct <= csr_pwdata[PCT_BITS-1:0];
            REG_PIX_FORMAT: cfg_ff.pixel_format      <= csr_pwdata[FMT_BITS-1:0];
            REG_WIN_LEFT:   cfg_ff.win_left          <= csr_pwdata[COORD_BITS-1:0];
            REG_WIN_TOP:    cfg_ff.win_top           <= csr_pwdata[COORD_BITS-1:0];
            REG_WIN_RIGHT:  cfg_ff.win_right         <= csr_pwdata[COORD_BITS:0];
            REG_WIN_BOTTOM: cfg_ff.win_bottom        <= csr_pwdata[COORD_BITS:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MIN_SAT:    csr_prdata = CSR_DATA_BITS'(cfg_ff.min_saturation);
         REG_MIN_VALUE:  csr_prdata = CSR_DATA_BITS'(cfg_ff.min_value);
         REG_RED_ADV:    csr_prdata = CSR_DATA_BITS'(cfg_ff.red_advantage_pct);
         REG_PIX_FORMAT: csr_prdata = CSR_DATA_BITS'(cfg_ff.pixel_format);
         REG_WIN_LEFT:   csr_prdata = CSR_DATA_BITS'(cfg_ff.win_left);
         REG_WIN_TOP:    csr_prdata = CSR_DATA_BITS'(cfg_ff.win_top);
         REG_WIN_RIGHT:  csr_prdata = CSR_DATA_BITS'(cfg_ff.win_right);
         REG_WIN_BOTTOM: csr_prdata = CSR_DATA_BITS'(cfg_ff.win_bottom);
         default:        csr_prdata = '0;
      endcase
   end

   lcv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   lcv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .head_data (q_head)
   );

   lcv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### design/lcv_checker.sv
// ----------------------------------------------------------------------------
// lcv_checker
// Port-level checks of the light color vote block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcv_checker import lcv_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire rsp_type                  rsp_data
);

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_red_needs_pixels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.light_red |-> rsp_data.active_total != '0)
      else $error("red vote with no active pixels");

   a_red_needs_lead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.light_red |-> rsp_data.red_total > rsp_data.green_total)
      else $error("red vote without red lead");

   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("results transfer back to back");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind light_color_vote lcv_checker u_lcv_checker (.*);

`default_nettype wire

### bench/lcv_vote_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcv_vote_checker
// Passive scoreboard for light_color_vote. It follows register writes on the
// APB port and keeps its own window, threshold and format settings. It keeps
// its own frame count and red and green sums, which active pixel transfers
// update. On each frame_end it queues the verdict it expects, and it checks
// every verdict transfer field by field against the oldest queued verdict.
// ----------------------------------------------------------------------------
module lcv_vote_checker import lcv_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  req_type                  req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  rsp_type                  rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic                     csr_pready,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output int                       fail_count,
   output int                       verdicts_pending,
   output int                       verdicts_checked,
   output int                       red_votes
);

   cfg_type               cfg;
   logic [COUNT_BITS-1:0] frame_count;
   logic [SUM_BITS-1:0]   frame_red;
   logic [SUM_BITS-1:0]   frame_green;
   rsp_type               verdicts_due[$];

   always @(posedge clock) begin : track
      logic [CH_BITS-1:0] r, g, b, hi, lo;
      int unsigned        sat;
      logic [SUM_BITS:0]  wide;
      logic               supported, in_window;
      logic [63:0]        scaled, needed;
      rsp_type            due, verdict;
      if (reset) begin
         cfg.min_saturation    = RST_MIN_SAT;
         cfg.min_value         = RST_MIN_VALUE;
         cfg.red_advantage_pct = RST_RED_ADV;
         cfg.pixel_format      = FMT_RGB888;
         cfg.win_left          = '0;
         cfg.win_top           = '0;
         cfg.win_right         = RST_WIN_END;
         cfg.win_bottom        = RST_WIN_END;
         frame_count      = '0;
         frame_red        = '0;
         frame_green      = '0;
         fail_count       = 0;
         verdicts_checked = 0;
         red_votes        = 0;
         verdicts_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_BITS-1:2])
               REG_MIN_SAT:    cfg.min_saturation    = csr_pwdata[CH_BITS-1:0];
               REG_MIN_VALUE:  cfg.min_value         = csr_pwdata[CH_BITS-1:0];
               REG_RED_ADV:    cfg.red_advantage_pct = csr_pwdata[PCT_BITS-1:0];
               REG_PIX_FORMAT: cfg.pixel_format      = csr_pwdata[FMT_BITS-1:0];
               REG_WIN_LEFT:   cfg.win_left          = csr_pwdata[COORD_BITS-1:0];
               REG_WIN_TOP:    cfg.win_top           = csr_pwdata[COORD_BITS-1:0];
               REG_WIN_RIGHT:  cfg.win_right         = csr_pwdata[COORD_BITS:0];
               REG_WIN_BOTTOM: cfg.win_bottom        = csr_pwdata[COORD_BITS:0];
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               $error("verdict transfer with no frame_end outstanding: %h", rsp_data);
               fail_count++;
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_data.light_red !== due.light_red) begin
                  $error("light_red: expected %0d, got %0d", due.light_red,
                         rsp_data.light_red);
                  fail_count++;
               end
               if (rsp_data.active_total !== due.active_total) begin
                  $error("active_total: expected %0d, got %0d", due.active_total,
                         rsp_data.active_total);
                  fail_count++;
               end
               if (rsp_data.red_total !== due.red_total) begin
                  $error("red_total: expected %0d, got %0d", due.red_total,
                         rsp_data.red_total);
                  fail_count++;
               end
               if (rsp_data.green_total !== due.green_total) begin
                  $error("green_total: expected %0d, got %0d", due.green_total,
                         rsp_data.green_total);
                  fail_count++;
               end
               verdicts_checked++;
               if (due.light_red) red_votes++;
            end
         end

         if (req_valid && req_ready) begin
            supported = cfg.pixel_format == FMT_RGB888 || cfg.pixel_format == FMT_BGR565;
            in_window = req_data.col >= cfg.win_left && req_data.col < cfg.win_right &&
                        req_data.row >= cfg.win_top && req_data.row < cfg.win_bottom;
            if (cfg.pixel_format == FMT_BGR565) begin
               r = {req_data.raw_pixel[15:11], req_data.raw_pixel[15:13]};
               g = {req_data.raw_pixel[10:5], req_data.raw_pixel[10:9]};
               b = {req_data.raw_pixel[4:0], req_data.raw_pixel[4:2]};
            end else begin
               r = req_data.raw_pixel[23:16];
               g = req_data.raw_pixel[15:8];
               b = req_data.raw_pixel[7:0];
            end
            hi = r;
            lo = r;
            if (g > hi) hi = g;
            if (b > hi) hi = b;
            if (g < lo) lo = g;
            if (b < lo) lo = b;
            sat = (hi == 0) ? 0 : (int'(hi - lo) * 255) / hi;
            if (supported && in_window && sat >= cfg.min_saturation &&
                hi >= cfg.min_value) begin
               if (frame_count != COUNT_MAX) frame_count++;
               wide = frame_red + r;
               frame_red = wide[SUM_BITS] ? SUM_MAX : wide[SUM_BITS-1:0];
               wide = frame_green + g;
               frame_green = wide[SUM_BITS] ? SUM_MAX : wide[SUM_BITS-1:0];
            end
            if (req_data.frame_end) begin
               verdict = '0;
               if (supported) begin
                  verdict.active_total = frame_count;
                  verdict.red_total    = frame_red;
                  verdict.green_total  = frame_green;
                  scaled = 64'(frame_red) * 64'd100;
                  needed = 64'(frame_green) * (64'd100 + 64'(cfg.red_advantage_pct));
                  verdict.light_red = frame_count != 0 && frame_red > frame_green &&
                                      scaled >= needed;
               end
               verdicts_due = {verdicts_due, verdict};
               frame_count = '0;
               frame_red   = '0;
               frame_green = '0;
            end
         end
      end
      verdicts_pending = verdicts_due.size();
   end

endmodule

### bench/tb_light_color_vote.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_light_color_vote
// Stimulus and verdict for light_color_vote. A directed opening covers pixel
// extremes, both formats, unsupported formats, window edges, empty and
// inverted windows and the vote threshold. Random frames then run under
// random register settings and three idle patterns, with one long verdict
// stall that backs up the pixel input. Checking is done by lcv_vote_checker.
// ----------------------------------------------------------------------------
module tb_light_color_vote;
   import lcv_pkg::*;

   localparam logic [FMT_BITS-1:0] FMT_UNSUP_LOW  = 2'd2;
   localparam logic [FMT_BITS-1:0] FMT_UNSUP_HIGH = 2'd3;
   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 200;
   localparam int DRAIN_CYCLES  = 16;
   localparam int RANDOM_PIXELS = 1400;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int      fail_count;
   int      verdicts_pending;
   int      verdicts_checked;
   int      red_votes;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      pixels_sent = 0;
   int      settings_loaded = 0;
   bit      hold_request = 1'b0;
   cfg_type live_cfg;

   light_color_vote dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   lcv_vote_checker vote_check (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .fail_count, .verdicts_pending, .verdicts_checked, .red_votes
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_config(input cfg_type c);
      write_reg(REG_MIN_SAT,    CSR_DATA_BITS'(c.min_saturation));
      write_reg(REG_MIN_VALUE,  CSR_DATA_BITS'(c.min_value));
      write_reg(REG_RED_ADV,    CSR_DATA_BITS'(c.red_advantage_pct));
      write_reg(REG_PIX_FORMAT, CSR_DATA_BITS'(c.pixel_format));
      write_reg(REG_WIN_LEFT,   CSR_DATA_BITS'(c.win_left));
      write_reg(REG_WIN_TOP,    CSR_DATA_BITS'(c.win_top));
      write_reg(REG_WIN_RIGHT,  CSR_DATA_BITS'(c.win_right));
      write_reg(REG_WIN_BOTTOM, CSR_DATA_BITS'(c.win_bottom));
      live_cfg = c;
      settings_loaded++;
   endtask

   // Drop valid, wait out every verdict, then let trailing pixels drain.
   task automatic settle();
      req_valid <= 1'b0;
      while (verdicts_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic send_pixel(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      pixels_sent++;
   endtask

   function automatic req_type pixel_at(input logic [PIX_BITS-1:0] raw, input int col,
                                        input int row, input logic last);
      req_type p;
      p.raw_pixel = raw;
      p.col       = COORD_BITS'(col);
      p.row       = COORD_BITS'(row);
      p.frame_end = last;
      return p;
   endfunction

   // Tint 0 leans red, 1 leans green, anything else is unbiased.
   function automatic req_type random_pixel(input int tint, input logic last);
      req_type p;
      logic [CH_BITS-1:0] r, g, b;
      int span_c, span_r;
      r = CH_BITS'($urandom_range(255));
      g = CH_BITS'($urandom_range(255));
      b = CH_BITS'($urandom_range(255));
      case (tint)
         0: begin
            r = CH_BITS'($urandom_range(255, 110));
            g = CH_BITS'($urandom_range(120));
            b = CH_BITS'($urandom_range(90));
         end
         1: begin
            g = CH_BITS'($urandom_range(255, 110));
            r = CH_BITS'($urandom_range(120));
            b = CH_BITS'($urandom_range(90));
         end
         default: ;
      endcase
      if ($urandom_range(9) == 0)
         p.raw_pixel = PIX_BITS'($urandom());
      else if (live_cfg.pixel_format == FMT_BGR565)
         p.raw_pixel = {8'($urandom()), r[7:3], g[7:2], b[7:3]};
      else
         p.raw_pixel = {r, g, b};
      span_c = int'(live_cfg.win_right) - int'(live_cfg.win_left);
      span_r = int'(live_cfg.win_bottom) - int'(live_cfg.win_top);
      if (span_c < 0) span_c = 0;
      if (span_r < 0) span_r = 0;
      if ($urandom_range(3) == 0)
         p.col = COORD_BITS'($urandom());
      else
         p.col = COORD_BITS'(int'(live_cfg.win_left) + int'($urandom_range(span_c + 8)) - 4);
      if ($urandom_range(3) == 0)
         p.row = COORD_BITS'($urandom());
      else
         p.row = COORD_BITS'(int'(live_cfg.win_top) + int'($urandom_range(span_r + 8)) - 4);
      p.frame_end = last;
      return p;
   endfunction

   task automatic send_frame();
      int len, tint;
      len  = ($urandom_range(7) == 0) ? 1 : $urandom_range(16, 2);
      tint = $urandom_range(2);
      for (int i = 1; i <= len; i++) send_pixel(random_pixel(tint, i == len));
   endtask

   function automatic cfg_type random_config();
      cfg_type c;
      int width;
      case ($urandom_range(7))
         0:       c.min_saturation = '0;
         1:       c.min_saturation = '1;
         default: c.min_saturation = CH_BITS'($urandom_range(160));
      endcase
      case ($urandom_range(7))
         0:       c.min_value = '0;
         1:       c.min_value = '1;
         default: c.min_value = CH_BITS'($urandom_range(160));
      endcase
      case ($urandom_range(7))
         0:       c.red_advantage_pct = '0;
         1:       c.red_advantage_pct = '1;
         default: c.red_advantage_pct = PCT_BITS'($urandom_range(100));
      endcase
      case ($urandom_range(15))
         0:          c.pixel_format = FMT_UNSUP_LOW;
         1:          c.pixel_format = FMT_UNSUP_HIGH;
         2, 3, 4, 5: c.pixel_format = FMT_BGR565;
         default:    c.pixel_format = FMT_RGB888;
      endcase
      case ($urandom_range(5))
         0: begin
            c.win_left   = '0;
            c.win_top    = '0;
            c.win_right  = RST_WIN_END;
            c.win_bottom = RST_WIN_END;
         end
         1: begin
            c.win_left   = COORD_BITS'($urandom());
            c.win_top    = COORD_BITS'($urandom());
            c.win_right  = (COORD_BITS+1)'($urandom_range(4096));
            c.win_bottom = (COORD_BITS+1)'($urandom_range(4096));
         end
         default: begin
            c.win_left   = COORD_BITS'($urandom());
            c.win_top    = COORD_BITS'($urandom());
            width        = $urandom_range(48, 1);
            c.win_right  = (int'(c.win_left) + width > 4096) ? RST_WIN_END
                                                             : (COORD_BITS+1)'(c.win_left + width);
            width        = $urandom_range(48, 1);
            c.win_bottom = (int'(c.win_top) + width > 4096) ? RST_WIN_END
                                                            : (COORD_BITS+1)'(c.win_top + width);
         end
      endcase
      return c;
   endfunction

   task automatic run_phase(input int sender_pct, input int receiver_pct, input bit with_hold);
      int goal;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      for (int k = 0; k < 2; k++) begin
         load_config(random_config());
         if (with_hold && k == 0) hold_request = 1'b1;
         goal = pixels_sent + RANDOM_PIXELS / 6;
         while (pixels_sent < goal) send_frame();
         settle();
      end
   endtask

   initial begin : receiver
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      cfg_type c;
      live_cfg.min_saturation    = RST_MIN_SAT;
      live_cfg.min_value         = RST_MIN_VALUE;
      live_cfg.red_advantage_pct = RST_RED_ADV;
      live_cfg.pixel_format      = FMT_RGB888;
      live_cfg.win_left          = '0;
      live_cfg.win_top           = '0;
      live_cfg.win_right         = RST_WIN_END;
      live_cfg.win_bottom        = RST_WIN_END;
      send_idle_pct = 19;
      recv_idle_pct = 63;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: channel extremes, black, gray, vote at and just under the margin
      send_pixel(pixel_at(24'hFF0000, 0, 0, 1'b0));
      send_pixel(pixel_at(24'h000000, 4095, 4095, 1'b0));
      send_pixel(pixel_at(24'hFFFFFF, 12'hAAA, 12'h555, 1'b0));
      send_pixel(pixel_at(24'h00FF00, 12'h555, 12'hAAA, 1'b1));
      send_pixel(pixel_at(24'hC81E00, 1, 1, 1'b1));
      send_pixel(pixel_at(24'h808080, 2, 2, 1'b1));
      send_pixel(pixel_at(24'hFAC800, 7, 7, 1'b1));
      send_pixel(pixel_at(24'hF9C800, 8, 8, 1'b1));
      settle();

      // BGR565 with zero thresholds and no advantage
      c = live_cfg;
      c.min_saturation    = '0;
      c.min_value         = '0;
      c.red_advantage_pct = '0;
      c.pixel_format      = FMT_BGR565;
      load_config(c);
      send_pixel(pixel_at(24'hFF0000, 0, 0, 1'b0));
      send_pixel(pixel_at(24'h00F800, 3, 4, 1'b0));
      send_pixel(pixel_at(24'h0007E0, 5, 6, 1'b0));
      send_pixel(pixel_at(24'h00001F, 7, 8, 1'b0));
      send_pixel(pixel_at(24'hFFFFFF, 9, 10, 1'b1));
      send_pixel(pixel_at(24'h00F800, 11, 12, 1'b1));
      settle();

      c.pixel_format = FMT_UNSUP_LOW;
      load_config(c);
      send_pixel(pixel_at(24'hFF0000, 0, 0, 1'b0));
      send_pixel(pixel_at(24'hFF0000, 1, 1, 1'b1));
      settle();
      c.pixel_format = FMT_UNSUP_HIGH;
      load_config(c);
      send_pixel(pixel_at(24'hFF0000, 2, 2, 1'b1));
      settle();

      // small window, strictest thresholds, largest margin
      c.min_saturation    = '1;
      c.min_value         = '1;
      c.red_advantage_pct = '1;
      c.pixel_format      = FMT_RGB888;
      c.win_left          = 12'd100;
      c.win_top           = 12'd200;
      c.win_right         = 13'd103;
      c.win_bottom        = 13'd202;
      load_config(c);
      send_pixel(pixel_at(24'hFF0000, 100, 200, 1'b0));
      send_pixel(pixel_at(24'hFF0000, 102, 201, 1'b0));
      send_pixel(pixel_at(24'hFF0000, 103, 200, 1'b0));
      send_pixel(pixel_at(24'hFF0000, 99, 200, 1'b0));
      send_pixel(pixel_at(24'h00FF00, 100, 202, 1'b0));
      send_pixel(pixel_at(24'hFE0000, 101, 199, 1'b1));
      settle();

      // inverted columns, then empty rows
      c.win_left   = 12'd4095;
      c.win_right  = 13'd0;
      c.win_top    = 12'd0;
      c.win_bottom = RST_WIN_END;
      load_config(c);
      send_pixel(pixel_at(24'hFF0000, 4095, 0, 1'b1));
      settle();
      c.win_left   = 12'd0;
      c.win_right  = RST_WIN_END;
      c.win_top    = 12'd4095;
      c.win_bottom = 13'd4095;
      load_config(c);
      send_pixel(pixel_at(24'hFF0000, 0, 4095, 1'b1));
      settle();

      run_phase(19, 63, 1'b0);
      run_phase(63, 19, 1'b0);
      run_phase(0, 0, 1'b1);

      settle();
      $display("Sent %0d pixels under %0d register settings; %0d verdicts checked, %0d red.",
               pixels_sent, settings_loaded, verdicts_checked, red_votes);
      $display("Covered both formats, unsupported formats, window edges, empty windows %s",
               "and a long verdict stall.");
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### files.f
design/lcv_pkg.sv
design/lcv_front.sv
design/lcv_queue.sv
design/lcv_back.sv
design/light_color_vote.sv
design/lcv_checker.sv
bench/lcv_vote_checker.sv
bench/tb_light_color_vote.sv
